>>> sv/awsu_pkg.sv
package awsu_pkg;

  localparam int MODE_W = 2;
  localparam int SYM_W  = 8;
  localparam int POS_W  = 32;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

  typedef struct packed {
    logic clr_all;
    logic clr_window;
  } clr_t;

endpackage

>>> sv/awsu_count_store.sv
module awsu_count_store #(
  parameter int ALPHABET = 256,
  parameter int CW       = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  awsu_pkg::clr_t              clr,
  input  logic                        rd_en,
  input  logic [$clog2(ALPHABET)-1:0] rd_addr_a,
  input  logic [$clog2(ALPHABET)-1:0] rd_addr_b,
  output logic [CW-1:0]               rd_pc_a,
  output logic [CW-1:0]               rd_wc_a,
  output logic [CW-1:0]               rd_pc_b,
  output logic [CW-1:0]               rd_wc_b,
  input  logic                        wr_en,
  input  logic [$clog2(ALPHABET)-1:0] wr_addr,
  input  logic [CW-1:0]               wr_pc,
  input  logic [CW-1:0]               wr_wc
);

  typedef struct packed {
    logic [CW-1:0] pc;
    logic [CW-1:0] wc;
    logic [CW-1:0] tag;
  } entry_t;

  entry_t mem [ALPHABET];
  entry_t q_a_r, q_b_r;

  logic [ALPHABET-1:0] pv_r, pv_nxt;
  logic [CW-1:0] ep_r, ep_nxt, rd_ep_r;
  logic va_p_r, va_w_r, vb_p_r, vb_w_r;
  logic fa_p_r, fa_w_r, fb_p_r, fb_w_r;
  logic [CW-1:0] f_pc_r, f_wc_r;
  logic hit_a, hit_b;

  // valid bits: an entry not written since the last full clear reads as zero
  always_comb begin
    pv_nxt = pv_r;
    if (wr_en) begin
      pv_nxt[wr_addr] = 1'b1;
    end
    if (clr.clr_all) begin
      pv_nxt = '0;
    end
  end

  // window epoch: a window count is live only when its tag matches;
  // it steps once per window restart, at most PATTERN_MAX times between full clears
  always_comb begin
    ep_nxt = ep_r;
    if (clr.clr_window) begin
      ep_nxt = ep_r + CW'(1);
    end
    if (clr.clr_all) begin
      ep_nxt = '0;
    end
  end

  // write in the same cycle as a read is forwarded
  assign hit_a = wr_en && (wr_addr == rd_addr_a) && !clr.clr_all;
  assign hit_b = wr_en && (wr_addr == rd_addr_b) && !clr.clr_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      ep_r <= '0;
    end else begin
      pv_r <= pv_nxt;
      ep_r <= ep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_pc, wr_wc, ep_r};
    end
    if (rd_en) begin
      q_a_r   <= mem[rd_addr_a];
      q_b_r   <= mem[rd_addr_b];
      rd_ep_r <= ep_nxt;
      va_p_r  <= pv_nxt[rd_addr_a];
      va_w_r  <= pv_r[rd_addr_a] && !clr.clr_all;
      vb_p_r  <= pv_nxt[rd_addr_b];
      vb_w_r  <= pv_r[rd_addr_b] && !clr.clr_all;
      fa_p_r  <= hit_a;
      fa_w_r  <= hit_a && !clr.clr_window;
      fb_p_r  <= hit_b;
      fb_w_r  <= hit_b && !clr.clr_window;
      f_pc_r  <= wr_pc;
      f_wc_r  <= wr_wc;
    end
  end

  assign rd_pc_a = fa_p_r ? f_pc_r : (va_p_r ? q_a_r.pc : '0);
  assign rd_wc_a = fa_w_r ? f_wc_r :
                   ((va_w_r && (q_a_r.tag == rd_ep_r)) ? q_a_r.wc : '0);
  assign rd_pc_b = fb_p_r ? f_pc_r : (vb_p_r ? q_b_r.pc : '0);
  assign rd_wc_b = fb_w_r ? f_wc_r :
                   ((vb_w_r && (q_b_r.tag == rd_ep_r)) ? q_b_r.wc : '0);

endmodule

>>> sv/anagram_window_search_unit.sv
// channel | dir | tdata                    | tuser
// in_     | in  | [7:0] symbol             | [1:0] mode
// out_    | out | [31:0] match_start       | -
//
// Stage b holding a word blocks the next: a text word needs two count updates
// (leaving and entering symbol) through the count memory's single write port.
// out_tvalid rises once a text word with a match passes stages b and c.
// Reset is synchronous; pattern counts clear through valid bits,
// window counts through an epoch tag kept in each entry.
// A result held in the output register stalls the last stage if that stage
// holds a match, and in_tready drops until the result is taken.
module anagram_window_search_unit #(
  parameter int PATTERN_MAX = 64,
  parameter int ALPHABET    = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [awsu_pkg::SYM_W-1:0]   in_tdata,   // [7:0] symbol
  input  logic [awsu_pkg::MODE_W-1:0]  in_tuser,   // [1:0] mode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [awsu_pkg::POS_W-1:0]   out_tdata   // [31:0] match_start
);

  localparam int SW    = $clog2(ALPHABET);
  localparam int CW    = $clog2(PATTERN_MAX + 1);
  localparam int PW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int DW    = $clog2(ALPHABET + 1);
  localparam int POS_W = awsu_pkg::POS_W;
  localparam int NSYM  = 2 ** awsu_pkg::SYM_W;

  typedef enum logic [1:0] {K_NOP, K_PAT, K_TEXT} kind_t;

  // symbol folded into the alphabet
  logic [SW-1:0] sym_mod [NSYM];
  for (genvar g = 0; g < NSYM; g++) begin : g_mod
    assign sym_mod[g] = SW'(g % ALPHABET);
  end

  logic [SW-1:0] sym_idx;
  logic          accept;

  logic [CW-1:0]    len_r, len_nxt, fill_r, fill_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt, ptr_adv;
  logic [POS_W-1:0] pos_r, pos_nxt, match;
  logic [DW-1:0]    distinct_r, distinct_nxt, diff_r, diff_nxt, diff_c, distinct_inc;
  logic [CW-1:0]    ptr_inc;
  logic             pat_ok, txt_live, evict, full_after, ring_we;
  kind_t            kind_in;
  awsu_pkg::clr_t   clr;

  logic [SW-1:0] ring [PATTERN_MAX];
  logic [SW-1:0] ring_q_r;

  logic             b_valid_r, b_evict_r, b_full_r;
  kind_t            b_kind_r;
  logic [SW-1:0]    b_sym_r, b_old_r;
  logic [POS_W-1:0] b_match_r;

  logic             c_valid_r, c_text_r, c_full_r;
  logic [SW-1:0]    c_sym_r;
  logic [CW-1:0]    c_pc_r, c_wc_r;
  logic [1:0]       c_up_r, c_dn_r;
  logic [POS_W-1:0] c_match_r;
  logic             c_hit, c_stall, c_fire;

  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_data_r;

  logic [CW-1:0] pc_a, wc_a, pc_b, wc_b, wc_b_dec, wc_s, wc_new;
  logic          dec, up1, dn1, up2, dn2;
  logic [1:0]    up_sum, dn_sum;

  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [CW-1:0] wr_pc, wr_wc;

  assign sym_idx = sym_mod[in_tdata];
  assign accept  = in_tvalid && in_tready;

  assign pat_ok     = len_r != CW'(PATTERN_MAX);
  assign txt_live   = len_r != '0;
  assign evict      = fill_r >= len_r;
  assign full_after = evict || ((fill_r + CW'(1)) == len_r);
  assign ptr_inc    = CW'(ptr_r) + CW'(1);
  assign ptr_adv    = (ptr_inc == len_r) ? '0 : PW'(ptr_inc);
  assign match      = pos_r - (POS_W'(len_r) - POS_W'(1));

  always_comb begin
    kind_in  = K_NOP;
    clr      = '0;
    ring_we  = 1'b0;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    if (accept) begin
      unique case (in_tuser)
        awsu_pkg::MODE_CLEAR: begin
          clr.clr_all = 1'b1;
          len_nxt     = '0;
          pos_nxt     = '0;
          fill_nxt    = '0;
          ptr_nxt     = '0;
        end
        awsu_pkg::MODE_PATTERN: begin
          if (pat_ok) begin
            kind_in        = K_PAT;
            clr.clr_window = 1'b1;
            len_nxt        = len_r + CW'(1);
            pos_nxt        = '0;
            fill_nxt       = '0;
            ptr_nxt        = '0;
          end
        end
        awsu_pkg::MODE_TEXT: begin
          pos_nxt = pos_r + POS_W'(1);
          if (txt_live) begin
            kind_in  = K_TEXT;
            ring_we  = 1'b1;
            fill_nxt = evict ? fill_r : fill_r + CW'(1);
            ptr_nxt  = ptr_adv;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ptr_r] <= sym_idx;
    end
    ring_q_r <= ring[ptr_r];
  end

  awsu_count_store #(
    .ALPHABET (ALPHABET),
    .CW       (CW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .rd_en     (accept),
    .rd_addr_a (sym_idx),
    .rd_addr_b (ring_q_r),
    .rd_pc_a   (pc_a),
    .rd_wc_a   (wc_a),
    .rd_pc_b   (pc_b),
    .rd_wc_b   (wc_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_pc     (wr_pc),
    .wr_wc     (wr_wc)
  );

  // count update of a text word: leaving symbol first, then entering symbol
  assign dec      = b_evict_r && (wc_b != '0);
  assign wc_b_dec = wc_b - CW'(1);
  assign up1      = dec && (wc_b == pc_b) && (wc_b_dec != pc_b);
  assign dn1      = dec && (wc_b != pc_b) && (wc_b_dec == pc_b);
  assign wc_s     = (dec && (b_old_r == b_sym_r)) ? wc_b_dec : wc_a;
  assign wc_new   = wc_s + CW'(1);
  assign up2      = (wc_s == pc_a) && (wc_new != pc_a);
  assign dn2      = (wc_s != pc_a) && (wc_new == pc_a);
  assign up_sum   = {1'b0, up1} + {1'b0, up2};
  assign dn_sum   = {1'b0, dn1} + {1'b0, dn2};

  assign distinct_inc = distinct_r + DW'(pc_a == '0);
  assign diff_c       = diff_r + DW'(c_up_r) - DW'(c_dn_r);

  assign c_hit   = c_valid_r && c_text_r && c_full_r && (diff_c == '0);
  assign c_stall = c_hit && out_valid_r && !out_tready;
  assign c_fire  = c_valid_r && !c_stall;

  assign in_tready = rst_n && !b_valid_r && !c_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = b_sym_r;
    wr_pc   = pc_a;
    wr_wc   = '0;
    if (b_valid_r && (b_kind_r == K_PAT)) begin
      wr_en = 1'b1;
      wr_pc = pc_a + CW'(1);
    end else if (b_valid_r && (b_kind_r == K_TEXT) && dec) begin
      wr_en   = 1'b1;
      wr_addr = b_old_r;
      wr_pc   = pc_b;
      wr_wc   = wc_b_dec;
    end else if (c_fire && c_text_r) begin
      wr_en   = 1'b1;
      wr_addr = c_sym_r;
      wr_pc   = c_pc_r;
      wr_wc   = c_wc_r;
    end
  end

  always_comb begin
    distinct_nxt = distinct_r;
    diff_nxt     = diff_r;
    if (c_fire && c_text_r) begin
      diff_nxt = diff_c;
    end
    if (b_valid_r && (b_kind_r == K_PAT)) begin
      distinct_nxt = distinct_inc;
      diff_nxt     = distinct_inc;
    end
    if (clr.clr_all) begin
      distinct_nxt = '0;
      diff_nxt     = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (c_fire && c_hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      pos_r       <= '0;
      distinct_r  <= '0;
      diff_r      <= '0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      pos_r       <= pos_nxt;
      distinct_r  <= distinct_nxt;
      diff_r      <= diff_nxt;
      b_valid_r   <= accept;
      c_valid_r   <= b_valid_r || c_stall;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind_r  <= kind_in;
      b_sym_r   <= sym_idx;
      b_old_r   <= ring_q_r;
      b_evict_r <= evict;
      b_full_r  <= full_after;
      b_match_r <= match;
    end
    if (b_valid_r) begin
      c_text_r  <= b_kind_r == K_TEXT;
      c_sym_r   <= b_sym_r;
      c_pc_r    <= pc_a;
      c_wc_r    <= wc_new;
      c_up_r    <= up_sum;
      c_dn_r    <= dn_sum;
      c_full_r  <= b_full_r;
      c_match_r <= b_match_r;
    end
    if (c_fire && c_hit) begin
      out_data_r <= c_match_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> sv/awsu_checker.sv
module awsu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [awsu_pkg::MODE_W-1:0] in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [awsu_pkg::POS_W-1:0]  out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // taking a word drops in_tready
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("word taken in back-to-back cycles");

  // a fresh result comes from a taken text word
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      $past(in_acc && (in_tuser == awsu_pkg::MODE_TEXT), 3))
    else $error("result without a text word");

  // a clear word never produces a result of its own
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == awsu_pkg::MODE_CLEAR) |=> ##2 !$rose(out_tvalid))
    else $error("result after clear");

endmodule

bind anagram_window_search_unit awsu_checker u_awsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
